// ===== rtl/breakpoint_address_table_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BREAKPOINT_ADDRESS_TABLE_DEFINES_SVH
`define BREAKPOINT_ADDRESS_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BAT_ASSERT_NOW(name, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BAT_ASSERT_NEXT(name, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bat_pkg.sv =====
`timescale 1ns / 1ps
package bat_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int ADDR_W      = 16;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_CHECK = 1'b1;

	// Token walking down the cell row.
	typedef struct packed {
		logic              valid;
		logic              kind;
		logic [ADDR_W-1:0] address;
		logic              done;    // some cell already answered
		logic              hit;
		logic              now_en;
	} tok_t;

endpackage

// ===== rtl/bat_cell.sv =====
`timescale 1ns / 1ps
// One table slot. Compares the passing token, updates its slot, forwards the token.
module bat_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  bat_pkg::tok_t tok_in,
	input  logic          hold,
	output bat_pkg::tok_t tok_out
);

	logic                       used_q;
	logic                       en_q;
	logic [bat_pkg::ADDR_W-1:0] addr_q;
	bat_pkg::tok_t              tok_q;
	bat_pkg::tok_t              tok_d;
	logic                       match;
	logic                       act;

	assign match = used_q && (addr_q == tok_in.address);
	assign act   = tok_in.valid && !tok_in.done && !hold;

	always_comb begin
		tok_d = tok_in;
		if (tok_in.valid && !tok_in.done) begin
			if (match) begin
				tok_d.done = 1'b1;
				if (tok_in.kind == bat_pkg::KIND_ADD) begin
					tok_d.now_en = !en_q;
				end else begin
					tok_d.hit = en_q;
				end
			end else if (!used_q) begin
				// first free slot: end of the stored entries
				tok_d.done = 1'b1;
				if (tok_in.kind == bat_pkg::KIND_ADD) begin
					tok_d.now_en = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			en_q   <= 1'b0;
		end else if (act && tok_in.kind == bat_pkg::KIND_ADD) begin
			if (match) begin
				en_q <= !en_q;
			end else if (!used_q) begin
				used_q <= 1'b1;
				en_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act && tok_in.kind == bat_pkg::KIND_ADD && !used_q) begin
			addr_q <= tok_in.address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.valid <= 1'b0;
		end else if (!hold) begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== rtl/breakpoint_address_table.sv =====
`timescale 1ns / 1ps
// Breakpoint address table: up to ENTRIES 16-bit addresses, each with an enable bit.
// Input channel (in_valid / in_stall): kind = add/toggle or check, plus address.
// Output channel (out_valid / out_stall): hit, now_enabled, dropped; one result per item.
// An accepted item becomes a token that walks a row of ENTRIES cells, one cell per
// cycle. Stored entries fill the row from cell 0 up, so the first cell that holds the
// address, or the first empty cell, answers the item; later cells pass it on.
// Each cell registers the token; the last cell feeds the output register behind out_valid.
// A new item is taken only after the token before it has left the cell row, since only
// one token is in the row at a time. in_stall is high while it walks.
// The result sits in an output register; a new item is taken while it waits.
// A stalled receiver holds the result; a finished token then parks in the last cell
// until the output register frees up.
// Reset empties the table (no entries, all disabled) and clears both channels.
module breakpoint_address_table #(
	parameter int ENTRIES = bat_pkg::ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [bat_pkg::ADDR_W-1:0] address,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output logic                       now_enabled,
	output logic                       dropped
);

	bat_pkg::tok_t chain [ENTRIES+1];
	bat_pkg::tok_t last;
	logic          busy_q;
	logic          accept;
	logic          last_move;
	logic          last_hold;
	logic          out_valid_q;
	logic          hit_q;
	logic          now_en_q;
	logic          dropped_q;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;

	// fresh token into cell 0
	always_comb begin
		chain[0].valid   = accept;
		chain[0].kind    = kind;
		chain[0].address = address;
		chain[0].done    = 1'b0;
		chain[0].hit     = 1'b0;
		chain[0].now_en  = 1'b0;
	end

	assign last      = chain[ENTRIES];
	assign last_move = last.valid && (!out_valid_q || !out_stall);
	assign last_hold = last.valid && out_valid_q && out_stall;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		bat_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (chain[i]),
			.hold   ((i == ENTRIES - 1) && last_hold),
			.tok_out(chain[i+1])
		);
	end

	// one token in the row at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (last_move) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// an add that no cell answered found the table full
	always_ff @(posedge clk) begin
		if (last_move) begin
			hit_q     <= last.hit;
			now_en_q  <= last.now_en;
			dropped_q <= (last.kind == bat_pkg::KIND_ADD) && !last.done;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign now_enabled = now_en_q;
	assign dropped     = dropped_q;

endmodule

// ===== rtl/bat_checker.sv =====
`timescale 1ns / 1ps
`include "breakpoint_address_table_defines.svh"
module bat_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       kind,
	input logic [bat_pkg::ADDR_W-1:0] address,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       hit,
	input logic                       now_enabled,
	input logic                       dropped
);

	logic in_xfer;

	assign in_xfer = in_valid && !in_stall;

	// only one item in flight: an input transfer closes the input side
	`BAT_ASSERT_NEXT(a_one_in_flight, in_xfer, in_stall, "second item taken while busy")

	// a result cannot appear the cycle after an item enters
	`BAT_ASSERT_NEXT(a_min_latency, in_xfer, !$rose(out_valid), "result too early")

	// at most one flag per result
	`BAT_ASSERT_NOW(a_flags_excl, out_valid, $countones({hit, now_enabled, dropped}) <= 1,
		"conflicting result flags")

	`BAT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result lost")

endmodule

bind breakpoint_address_table bat_checker u_bat_checker (.*);

// ===== tb/breakpoint_address_table_tb.sv =====
`timescale 1ns / 1ps
module breakpoint_address_table_tb;

	localparam int TABLE_SLOTS = bat_pkg::ENTRIES_DEF;
	localparam int RANDOM_OPS  = 1000;

	typedef struct packed {
		logic hit;
		logic now_enabled;
		logic dropped;
	} bp_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       kind = bat_pkg::KIND_ADD;
	logic [bat_pkg::ADDR_W-1:0] address = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       hit;
	logic                       now_enabled;
	logic                       dropped;

	// Shadow copy of the table, updated at every input transfer
	logic [bat_pkg::ADDR_W-1:0] tbl_addr [TABLE_SLOTS];
	logic                       tbl_en   [TABLE_SLOTS];
	int                         tbl_count = 0;

	bp_result_t pending_results[$];
	bp_result_t due;
	int         error_count = 0;
	bit         no_idle = 1'b0;   // both sides run flat out while set

	breakpoint_address_table u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.address    (address),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.now_enabled(now_enabled),
		.dropped    (dropped)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one add/toggle or check to the shadow table and return the answer.
	// Only slots below tbl_count are ever looked at.
	function automatic bp_result_t apply_breakpoint_op(input logic k,
			input logic [bat_pkg::ADDR_W-1:0] a);
		bp_result_t r;
		int         slot;
		r    = '0;
		slot = -1;
		for (int i = 0; i < tbl_count; i++) begin
			if (slot < 0 && tbl_addr[i] == a)
				slot = i;
		end
		if (k == bat_pkg::KIND_ADD) begin
			if (slot >= 0) begin
				// known address: flip its enable (lowest match, there is only one)
				tbl_en[slot]  = ~tbl_en[slot];
				r.now_enabled = tbl_en[slot];
			end else if (tbl_count < TABLE_SLOTS) begin
				tbl_addr[tbl_count] = a;
				tbl_en[tbl_count]   = 1'b1;
				tbl_count++;
				r.now_enabled = 1'b1;
			end else begin
				// full table, unknown address: nothing stored
				r.dropped = 1'b1;
			end
		end else begin
			r.hit = (slot >= 0) && tbl_en[slot];
		end
		return r;
	endfunction

	// Drive one item from a falling edge, hold it until the transfer, then
	// return on the next falling edge with in_valid still high.
	task automatic send_op(input logic k, input logic [bat_pkg::ADDR_W-1:0] a);
		while (!no_idle && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		address  <= a;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(apply_breakpoint_op(k, a));
		@(negedge clk);
	endtask

	// Sender holds off until every result that is due has come out.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	// Empty table, both extreme addresses, toggle off and back on
	task automatic test_empty_table_toggle();
		send_op(bat_pkg::KIND_CHECK, 16'h0000);   // nothing stored yet
		send_op(bat_pkg::KIND_ADD,   16'h0000);
		send_op(bat_pkg::KIND_CHECK, 16'h0000);
		send_op(bat_pkg::KIND_ADD,   16'hFFFF);
		send_op(bat_pkg::KIND_CHECK, 16'hFFFF);
		send_op(bat_pkg::KIND_ADD,   16'h0000);   // disable, entry keeps its slot
		send_op(bat_pkg::KIND_CHECK, 16'h0000);
		send_op(bat_pkg::KIND_ADD,   16'h0000);   // enable again
	endtask

	// Walking ones fill the remaining slots; then overflow and toggle while full
	task automatic test_fill_and_overflow();
		for (int b = 0; b < TABLE_SLOTS - 2; b++)
			send_op(bat_pkg::KIND_ADD, 16'h0001 << b);
		send_op(bat_pkg::KIND_ADD,   16'h8000);   // no room: dropped
		send_op(bat_pkg::KIND_CHECK, 16'h8000);
		send_op(bat_pkg::KIND_ADD,   16'h0001);   // toggle still works when full
		send_op(bat_pkg::KIND_CHECK, 16'h0001);
		wait_for_results();
	endtask

	// Mostly stored addresses, some near misses, some anything at all
	task automatic test_random_traffic();
		int                         roll;
		logic                       k;
		logic [bat_pkg::ADDR_W-1:0] a;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			no_idle = (n >= 400 && n < 550);
			if (n == 500)
				wait_for_results();
			roll = $urandom_range(99);
			k    = 1'($urandom_range(1));
			if (tbl_count == 0 || roll >= 75)
				a = 16'($urandom_range(16'hFFFF));
			else if (roll < 55)
				a = tbl_addr[$urandom_range(tbl_count - 1)];
			else
				a = tbl_addr[$urandom_range(tbl_count - 1)] ^ (16'h0001 << $urandom_range(15));
			send_op(k, a);
		end
		no_idle = 1'b0;
	endtask

	// Receiver stall, changed on the falling edge
	always @(negedge clk) begin
		if (arst_n)
			out_stall <= !no_idle && ($urandom_range(99) < 19);
	end

	// Result check on every output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing pending: hit=%0b now_enabled=%0b dropped=%0b",
					hit, now_enabled, dropped);
				error_count++;
			end else begin
				due = pending_results.pop_front();
				if (hit !== due.hit) begin
					$error("hit: expected %0b, got %0b", due.hit, hit);
					error_count++;
				end
				if (now_enabled !== due.now_enabled) begin
					$error("now_enabled: expected %0b, got %0b", due.now_enabled, now_enabled);
					error_count++;
				end
				if (dropped !== due.dropped) begin
					$error("dropped: expected %0b, got %0b", due.dropped, dropped);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_table_toggle();
		test_fill_and_overflow();
		test_random_traffic();
		wait_for_results();
		// then give any remaining token time to leave the row
		repeat (TABLE_SLOTS + 4) @(negedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("breakpoint_address_table_tb: clean");
		else
			$display("breakpoint_address_table_tb: errors");
		$finish;
	end

	// Watchdog, several times the slowest legal run
	initial begin
		#2_000_000;
		$display("breakpoint_address_table_tb: errors");
		$finish;
	end

endmodule
